// File: hdl/tws_pkg.sv
// Shared types, codes and helpers of the timeline word scheduler.
package tws_pkg;

   localparam int TIME_W     = 40;
   localparam int IVAL_W     = 24;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [IVAL_W-1:0] TICK_PERIOD_RST = 24'd90000;

   // Register index within the configuration space (paddr[2]).
   localparam logic REG_TICK_PERIOD = 1'b0;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [2:0] KIND_ADDED    = 3'd0;
   localparam logic [2:0] KIND_REJECTED = 3'd1;
   localparam logic [2:0] KIND_START    = 3'd2;
   localparam logic [2:0] KIND_STEP     = 3'd3;
   localparam logic [2:0] KIND_STOP     = 3'd4;
   localparam logic [2:0] KIND_TIMEOUT  = 3'd5;
   localparam logic [2:0] KIND_COMPLETE = 3'd6;
   localparam logic [2:0] KIND_IGNORED  = 3'd7;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [TIME_W-1:0] start_offset_us;
      logic [TIME_W-1:0] duration_us;
      logic [TIME_W-1:0] now_us;
      logic [TIME_W-1:0] due_us;
   } req_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [3:0]        word_index;
      logic [TIME_W-1:0] next_time_us;
      logic              last;
   } rsp_type;

   // Entry of the word memory, written by add items.
   typedef struct packed {
      logic [TIME_W-1:0] offset;
      logic [TIME_W-1:0] duration;
   } word_type;

   // Entry of the span memory, written when a program starts.
   typedef struct packed {
      logic [TIME_W-1:0] begin_us;
      logic [TIME_W-1:0] end_us;
   } span_type;

   // Time sums clamp at the largest representable time.
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   endfunction

endpackage

// File: hdl/tws_csr.sv
// Configuration register block holding the step interval.
module tws_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tws_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tws_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tws_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [tws_pkg::IVAL_W-1:0]      tick_period
);
   import tws_pkg::*;

   logic [IVAL_W-1:0] interval_ff;
   logic [IVAL_W-1:0] interval_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TICK_PERIOD);

   always_comb begin
      interval_in = interval_ff;
      if (wr_en) begin
         interval_in = pwdata[IVAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= TICK_PERIOD_RST;
      end else begin
         interval_ff <= interval_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_TICK_PERIOD) begin
         prdata = {{(CSR_DATA_W-IVAL_W){1'b0}}, interval_ff};
      end
   end

   assign tick_period = interval_ff;

endmodule

// File: hdl/tws_ctrl.sv
// Sequencer with the word and span memories: add, start sweep and tick walk.
module tws_ctrl #(
   parameter int WORD_SLOTS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  tws_pkg::req_type            req_item,
   output logic                        rsp_strobe,
   output tws_pkg::rsp_type            rsp_item,
   input  logic [tws_pkg::IVAL_W-1:0]  tick_period
);
   import tws_pkg::*;

   localparam int CNT_W  = $clog2(WORD_SLOTS + 1);
   localparam int ADDR_W = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_ST_RD, S_ST_A, S_ST_B, S_ST_END, S_TK_NEXT,
      S_TK_RD, S_TK_EVAL, S_TK_STOP, S_FA_RD, S_FA_EVAL
   } state_type;

   // Memories.
   word_type word_mem [WORD_SLOTS];
   span_type span_mem [WORD_SLOTS];

   logic              a_we, a_re, b_we, b_re;
   logic [ADDR_W-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
   word_type          a_wdata, a_rdata_ff;
   span_type          b_wdata, b_rdata_ff;

   // Control state.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  fa_ff, fa_in;
   logic              running_ff, running_in;
   logic              phase_ff, phase_in;
   logic              strobe_ff, strobe_in;

   // Payload registers.
   logic [TIME_W-1:0] last_off_ff, last_off_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] due_ff, due_in;
   logic [TIME_W-1:0] next_ff, next_in;
   logic [TIME_W-1:0] astart_ff, astart_in;
   logic [TIME_W-1:0] dur_ff, dur_in;
   logic [TIME_W-1:0] first_start_ff, first_start_in;
   rsp_type           rsp_ff, rsp_in;

   // Result being issued this cycle.
   logic              emit;
   logic [2:0]        emit_kind;
   logic [CNT_W-1:0]  emit_idx;
   logic [TIME_W-1:0] emit_time;
   logic              emit_last;
   logic [CNT_W+3:0]  emit_idx_wide;

   logic              due_gt_start, due_gt_stop, next_gt_start, next_gt_stop;
   logic [TIME_W-1:0] stop_sum;

   assign due_gt_start  = due_ff  > b_rdata_ff.begin_us;
   assign due_gt_stop   = due_ff  > b_rdata_ff.end_us;
   assign next_gt_start = next_ff > b_rdata_ff.begin_us;
   assign next_gt_stop  = next_ff > b_rdata_ff.end_us;
   assign stop_sum      = sat_add(astart_ff, dur_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      fa_in          = fa_ff;
      running_in     = running_ff;
      phase_in       = phase_ff;
      last_off_in    = last_off_ff;
      now_in         = now_ff;
      due_in         = due_ff;
      next_in        = next_ff;
      astart_in      = astart_ff;
      dur_in         = dur_ff;
      first_start_in = first_start_ff;

      a_we    = 1'b0;
      a_waddr = count_ff[ADDR_W-1:0];
      a_wdata = '{offset: req_item.start_offset_us, duration: req_item.duration_us};
      a_re    = 1'b0;
      a_raddr = idx_ff[ADDR_W-1:0];
      b_we    = 1'b0;
      b_waddr = idx_ff[ADDR_W-1:0];
      b_wdata = '{begin_us: astart_ff, end_us: stop_sum};
      b_re    = 1'b0;
      b_raddr = idx_ff[ADDR_W-1:0];

      emit      = 1'b0;
      emit_kind = KIND_IGNORED;
      emit_idx  = '0;
      emit_time = '0;
      emit_last = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_item.cmd == CMD_ADD) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  if (running_ff || count_ff >= CNT_W'(WORD_SLOTS) ||
                      (count_ff != '0 && last_off_ff > req_item.start_offset_us)) begin
                     emit_kind = KIND_REJECTED;
                  end else begin
                     a_we        = 1'b1;
                     emit_kind   = KIND_ADDED;
                     emit_idx    = count_ff;
                     count_in    = count_ff + CNT_W'(1);
                     last_off_in = req_item.start_offset_us;
                  end
               end else if (req_item.cmd == CMD_START && count_ff != '0) begin
                  fa_in      = '0;
                  idx_in     = '0;
                  running_in = 1'b1;
                  now_in     = req_item.now_us;
                  state_in   = S_ST_RD;
               end else if (req_item.cmd == CMD_TICK && running_ff) begin
                  now_in   = req_item.now_us;
                  due_in   = req_item.due_us;
                  idx_in   = fa_ff;
                  phase_in = 1'b0;
                  state_in = S_TK_NEXT;
               end else begin
                  emit      = 1'b1;
                  emit_kind = KIND_IGNORED;
                  emit_last = 1'b1;
               end
            end
         end
         S_ST_RD: begin
            if (idx_ff < count_ff) begin
               a_re     = 1'b1;
               state_in = S_ST_A;
            end else begin
               state_in = S_ST_END;
            end
         end
         S_ST_A: begin
            astart_in = sat_add(a_rdata_ff.offset, now_ff);
            dur_in    = a_rdata_ff.duration;
            state_in  = S_ST_B;
         end
         S_ST_B: begin
            b_we   = 1'b1;
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff == '0) begin
               first_start_in = astart_ff;
            end
            state_in = S_ST_RD;
         end
         S_ST_END: begin
            if (first_start_ff == now_ff) begin
               // The first word begins right away, so run a tick now.
               due_in   = now_ff;
               idx_in   = '0;
               phase_in = 1'b0;
               state_in = S_TK_NEXT;
            end else begin
               emit      = 1'b1;
               emit_kind = KIND_TIMEOUT;
               emit_time = first_start_ff;
               emit_last = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_TK_NEXT: begin
            next_in  = sat_add(now_ff, {{(TIME_W-IVAL_W){1'b0}}, tick_period});
            state_in = S_TK_RD;
         end
         S_TK_RD: begin
            if (idx_ff < count_ff) begin
               b_re     = 1'b1;
               state_in = S_TK_EVAL;
            end else begin
               state_in = S_FA_RD;
            end
         end
         S_TK_EVAL: begin
            if (!phase_ff) begin
               // Words already playing when the timeout fired.
               if (due_gt_start) begin
                  if (!due_gt_stop) begin
                     emit      = 1'b1;
                     emit_kind = next_gt_stop ? KIND_STOP : KIND_STEP;
                     emit_idx  = idx_ff;
                  end
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_TK_RD;
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               // Words that begin before the next timeout.
               if (next_gt_start) begin
                  emit      = 1'b1;
                  emit_kind = KIND_START;
                  emit_idx  = idx_ff;
                  if (next_gt_stop) begin
                     state_in = S_TK_STOP;
                  end else begin
                     idx_in   = idx_ff + CNT_W'(1);
                     state_in = S_TK_RD;
                  end
               end else begin
                  state_in = S_FA_RD;
               end
            end
         end
         S_TK_STOP: begin
            emit      = 1'b1;
            emit_kind = KIND_STOP;
            emit_idx  = idx_ff;
            idx_in    = idx_ff + CNT_W'(1);
            state_in  = S_TK_RD;
         end
         S_FA_RD: begin
            b_raddr = fa_ff[ADDR_W-1:0];
            if (fa_ff < count_ff) begin
               b_re     = 1'b1;
               state_in = S_FA_EVAL;
            end else begin
               running_in = 1'b0;
               emit       = 1'b1;
               emit_kind  = KIND_COMPLETE;
               emit_last  = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_FA_EVAL: begin
            if (next_gt_stop) begin
               fa_in    = fa_ff + CNT_W'(1);
               state_in = S_FA_RD;
            end else begin
               emit      = 1'b1;
               emit_kind = KIND_TIMEOUT;
               emit_time = next_gt_start ? next_ff : b_rdata_ff.begin_us;
               emit_last = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign emit_idx_wide = {4'b0000, emit_idx};
   assign strobe_in     = emit;

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.kind         = emit_kind;
      rsp_in.word_index   = emit_idx_wide[3:0];
      rsp_in.next_time_us = emit_time;
      rsp_in.last         = emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         idx_ff     <= '0;
         fa_ff      <= '0;
         running_ff <= 1'b0;
         phase_ff   <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         fa_ff      <= fa_in;
         running_ff <= running_in;
         phase_ff   <= phase_in;
         strobe_ff  <= strobe_in;
      end
      last_off_ff    <= last_off_in;
      now_ff         <= now_in;
      due_ff         <= due_in;
      next_ff        <= next_in;
      astart_ff      <= astart_in;
      dur_ff         <= dur_in;
      first_start_ff <= first_start_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         word_mem[a_waddr] <= a_wdata;
      end
      if (a_re) begin
         a_rdata_ff <= word_mem[a_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         span_mem[b_waddr] <= b_wdata;
      end
      if (b_re) begin
         b_rdata_ff <= span_mem[b_raddr];
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// File: hdl/timeline_word_scheduler_top.sv
// Top level of the timeline word scheduler.
//
// Items enter on req_item and are taken at a clock edge with start high and
// busy low. Each result appears on rsp_item for exactly one cycle with
// rsp_strobe high; the receiver cannot stall, and rsp_item.last marks the
// final result of an item. The step interval register sits at byte address 0
// of the APB-style port (pready is always high).
// An add or an ignored command gives its single result in the cycle after it
// is taken, and busy stays low, so the next item may follow at once.
// A start sweeps the word memory one word at a time (read, start sum, stop
// sum and span write), then reports the first timeout or begins a tick. A
// tick first sums the next timeout, then reads and evaluates each word walked,
// with an extra step for a word that both starts and stops and one where the
// walk turns to words not yet started, then reads and checks each word that
// the first-active index passes, and finishes; each result is registered.
// Reset clears the word count, the first-active index, the running flag and
// the step interval (back to 90000); the memories need no clearing pass.
module timeline_word_scheduler_top #(
   parameter int WORD_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  tws_pkg::req_type                req_item,
   output logic                            rsp_strobe,
   output tws_pkg::rsp_type                rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tws_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tws_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tws_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import tws_pkg::*;

   logic [IVAL_W-1:0] tick_period;

   tws_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .tick_period (tick_period)
   );

   tws_ctrl #(
      .WORD_SLOTS (WORD_SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .tick_period (tick_period)
   );

endmodule

// File: hdl/tws_checker.sv
// Port-level checks of the timeline word scheduler, bound to the top level.
module tws_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input tws_pkg::rsp_type rsp_item
);
   import tws_pkg::*;

   // A taken item either occupies the block or answers in the next cycle.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("item taken without work or result");

   // More results are still to come, so the block must stay occupied.
   a_more_means_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> busy)
      else $error("non-final result while idle");

   // The final result of an item frees the block.
   a_last_means_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last |-> !busy)
      else $error("final result while still busy");

   // The block goes idle only together with a final result.
   a_idle_with_last: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe && rsp_item.last)
      else $error("busy dropped without a final result");

   // Add, reject and ignore answers are always single results.
   a_single_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.kind == KIND_ADDED || rsp_item.kind == KIND_REJECTED ||
                     rsp_item.kind == KIND_IGNORED) |-> rsp_item.last)
      else $error("single-result kind not marked last");

endmodule

bind timeline_word_scheduler_top tws_checker u_tws_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
